// File: sv/tcp_connection_lookup_assert.svh
// Assertion macros shared by the connection lookup RTL.
`ifndef TCP_CONNECTION_LOOKUP_ASSERT_SVH
`define TCP_CONNECTION_LOOKUP_ASSERT_SVH

`ifndef ASSERT_OFF

`define TCL_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("connection lookup assertion failed");

`define TCL_ASSERT_NEVER(name, clk, rst_n, cond) \
    `TCL_ASSERT(name, clk, rst_n, !(cond))

`else

`define TCL_ASSERT(name, clk, rst_n, prop)
`define TCL_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

// File: sv/tcl_pkg.sv
`default_nettype none

package tcl_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int SLOT_W  = 4;
    localparam int CLASS_W = 2;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;

    localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [CLASS_W-1:0] CLASS_ACTIVE   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_TIMEWAIT = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_LISTEN   = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_RESERVED = 2'd3;

    typedef struct packed {
        logic               valid;
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic               slot_valid;
        logic [CLASS_W-1:0] slot_class;
        logic [ADDR_W-1:0]  local_address;
        logic [PORT_W-1:0]  local_port;
        logic [ADDR_W-1:0]  remote_address;
        logic [PORT_W-1:0]  remote_port;
        logic               found;
        logic [CLASS_W-1:0] best_class;
        logic [IDX_W-1:0]   best_idx;
    } t_token;

endpackage

`default_nettype wire

// File: sv/tcl_if.sv
`default_nettype none

interface tcl_req_if import tcl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [SLOT_W-1:0]  slot;
    logic               slot_valid;
    logic [CLASS_W-1:0] slot_class;
    logic [ADDR_W-1:0]  local_address;
    logic [PORT_W-1:0]  local_port;
    logic [ADDR_W-1:0]  remote_address;
    logic [PORT_W-1:0]  remote_port;

    modport source (
        output valid, kind, slot, slot_valid, slot_class,
        output local_address, local_port, remote_address, remote_port,
        input  ready
    );

    modport sink (
        input  valid, kind, slot, slot_valid, slot_class,
        input  local_address, local_port, remote_address, remote_port,
        output ready
    );
endinterface

interface tcl_rsp_if import tcl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [SLOT_W-1:0] match_slot;

    modport source (output valid, found, match_slot, input ready);
    modport sink (input valid, found, match_slot, output ready);
endinterface

`default_nettype wire

// File: sv/tcl_cell.sv
`default_nettype none

`include "tcp_connection_lookup_assert.svh"

module tcl_cell import tcl_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire t_token           i_tok,
    output t_token                o_tok
);

    logic               r_used;
    logic [CLASS_W-1:0] r_class;
    logic [ADDR_W-1:0]  r_laddr;
    logic [PORT_W-1:0]  r_lport;
    logic [ADDR_W-1:0]  r_raddr;
    logic [PORT_W-1:0]  r_rport;
    t_token             r_tok;
    t_token             n_tok;

    logic hit;
    logic take;
    logic wr;

    always_comb begin
        hit = r_used && (r_class != CLASS_RESERVED) && (r_lport == i_tok.local_port)
            && ((r_laddr == '0) || (r_laddr == i_tok.local_address))
            && ((r_class == CLASS_LISTEN) || (i_tok.remote_port == '0)
                || ((r_rport == i_tok.remote_port)
                    && ((r_raddr == '0) || (r_raddr == i_tok.remote_address))));
        take = i_tok.valid && (i_tok.kind == KIND_LOOKUP) && hit
            && (!i_tok.found || (r_class < i_tok.best_class));
        wr = i_tok.valid && (i_tok.kind == KIND_WRITE)
            && (CMP_W'(i_tok.slot) == CMP_W'(i_index));
        n_tok = i_tok;
        if (take) begin
            n_tok.found      = 1'b1;
            n_tok.best_class = r_class;
            n_tok.best_idx   = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
            if (wr) begin
                r_used <= i_tok.slot_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && wr) begin
            r_class <= i_tok.slot_class;
            r_laddr <= i_tok.local_address;
            r_lport <= i_tok.local_port;
            r_raddr <= i_tok.remote_address;
            r_rport <= i_tok.remote_port;
        end
    end

    assign o_tok = r_tok;

    // A match never carries the reserved class, and a write never picks up a match.
    `TCL_ASSERT(a_found_class, i_clk, i_rst_n,
        (r_tok.valid && r_tok.found) |-> (r_tok.best_class != CLASS_RESERVED))
    `TCL_ASSERT_NEVER(a_write_no_match, i_clk, i_rst_n,
        r_tok.valid && (r_tok.kind == KIND_WRITE) && r_tok.found)

endmodule

`default_nettype wire

// File: sv/tcp_connection_lookup.sv
// TCP connection table with lookup for segment demultiplexing.
// Input channel i_req carries one word per operation: kind selects a table write
// (slot, valid flag, class, addresses and ports) or a lookup (addresses and ports).
// Output channel o_rsp carries one word per lookup: found and match_slot.
// A write gives no output word.
// Every word travels through a row of TABLE_ENTRIES cells, one cell per cycle
// while the row advances; each cell holds one table entry, applies a write
// addressed to it and updates the best match of a passing lookup. Operations
// therefore keep their order. A result passes through one register per cell and
// then the output register before it reaches o_rsp, and one word can be accepted
// in every cycle in which the row is not held.
// Reset clears every valid flag and empties the row; i_req is not ready during
// reset. When the receiver stalls with a result waiting, the whole row holds
// and i_req.ready falls until the result is taken.
`default_nettype none

`include "tcp_connection_lookup_assert.svh"

module tcp_connection_lookup import tcl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcl_req_if.sink   i_req,
    tcl_rsp_if.source o_rsp
);

    t_token w_tok [TABLE_ENTRIES+1];
    logic   adv;

    logic              r_out_valid;
    logic              r_found;
    logic [SLOT_W-1:0] r_slot;

    assign adv         = !r_out_valid || o_rsp.ready;
    assign i_req.ready = adv && i_rst_n;

    always_comb begin
        w_tok[0].valid          = i_req.valid && i_req.ready;
        w_tok[0].kind           = i_req.kind;
        w_tok[0].slot           = i_req.slot;
        w_tok[0].slot_valid     = i_req.slot_valid;
        w_tok[0].slot_class     = i_req.slot_class;
        w_tok[0].local_address  = i_req.local_address;
        w_tok[0].local_port     = i_req.local_port;
        w_tok[0].remote_address = i_req.remote_address;
        w_tok[0].remote_port    = i_req.remote_port;
        w_tok[0].found          = 1'b0;
        w_tok[0].best_class     = CLASS_RESERVED;
        w_tok[0].best_idx       = '0;
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        tcl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_index (IDX_W'(g)),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= w_tok[TABLE_ENTRIES].valid
                && (w_tok[TABLE_ENTRIES].kind == KIND_LOOKUP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_found <= w_tok[TABLE_ENTRIES].found;
            r_slot  <= SLOT_W'(w_tok[TABLE_ENTRIES].best_idx);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_found;
    assign o_rsp.match_slot = r_slot;

    `TCL_ASSERT(a_miss_slot_zero, i_clk, i_rst_n,
        (r_out_valid && !r_found) |-> (r_slot == '0))
    `TCL_ASSERT(a_write_no_word, i_clk, i_rst_n,
        (adv && w_tok[TABLE_ENTRIES].valid && (w_tok[TABLE_ENTRIES].kind == KIND_WRITE))
            |=> !r_out_valid)
    `TCL_ASSERT(a_lookup_word, i_clk, i_rst_n,
        (adv && w_tok[TABLE_ENTRIES].valid && (w_tok[TABLE_ENTRIES].kind == KIND_LOOKUP))
            |=> r_out_valid)
    `TCL_ASSERT(a_stall_holds, i_clk, i_rst_n,
        !adv |=> $stable(w_tok[TABLE_ENTRIES]))

endmodule

`default_nettype wire
